// ===== rtl/bett_pkg.sv =====
`default_nettype none

package bett_pkg;

  // table size and register reset
  localparam int unsigned MAX_EVENTS_DEF = 64;
  localparam logic [31:0] SPB_RESET      = 32'd1572864000;

  // field widths
  localparam int unsigned BEAT_W  = 32;
  localparam int unsigned SAMP_W  = 16;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned START_W = 48;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned SPB_W   = 32;

  // input beat modes
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_BLOCK = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // one table entry as stored in the event memory
  typedef struct packed {
    logic [BEAT_W-1:0] beat;
    logic [SAMP_W-1:0] sample;
    logic [VEL_W-1:0]  velocity;
  } event_t;

  // one result beat
  typedef struct packed {
    logic [SAMP_W-1:0] fired_sample;
    logic [VEL_W-1:0]  fired_velocity;
    logic [SLOT_W-1:0] fired_slot;
    logic              last_in_block;
  } res_t;

  // push request from the scan control to the output stage
  typedef struct packed {
    logic push;
    res_t res;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/bett_in_if.sv =====
`default_nettype none

interface bett_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [bett_pkg::BEAT_W-1:0]   beat_position;
  logic [bett_pkg::SAMP_W-1:0]   sample_id_in;
  logic [bett_pkg::VEL_W-1:0]    velocity_in;
  logic [bett_pkg::START_W-1:0]  block_start;
  logic [bett_pkg::LEN_W-1:0]    block_length;
  logic                          playing;

  modport source (
    output valid, mode, beat_position, sample_id_in, velocity_in,
           block_start, block_length, playing,
    input  ready
  );

  modport sink (
    input  valid, mode, beat_position, sample_id_in, velocity_in,
           block_start, block_length, playing,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/bett_out_if.sv =====
`default_nettype none

interface bett_out_if;
  logic                         valid;
  logic                         ready;
  logic [bett_pkg::SAMP_W-1:0]  fired_sample;
  logic [bett_pkg::VEL_W-1:0]   fired_velocity;
  logic [bett_pkg::SLOT_W-1:0]  fired_slot;
  logic                         last_in_block;

  modport source (
    output valid, fired_sample, fired_velocity, fired_slot, last_in_block,
    input  ready
  );

  modport sink (
    input  valid, fired_sample, fired_velocity, fired_slot, last_in_block,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/bett_event_mem.sv =====
`default_nettype none

module bett_event_mem #(
  parameter int unsigned DEPTH = bett_pkg::MAX_EVENTS_DEF,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire bett_pkg::event_t wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output bett_pkg::event_t      rdata_o
);

  bett_pkg::event_t mem [DEPTH];
  bett_pkg::event_t rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/bett_out_stage.sv =====
`default_nettype none

module bett_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bett_pkg::push_t push_i,
  output logic                free_o,
  bett_out_if.source          out_o
);

  logic           valid_q;
  bett_pkg::res_t res_q;

  // register is free when empty or being taken this cycle
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i.push) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      res_q <= push_i.res;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.fired_sample   = res_q.fired_sample;
  assign out_o.fired_velocity = res_q.fired_velocity;
  assign out_o.fired_slot     = res_q.fired_slot;
  assign out_o.last_in_block  = res_q.last_in_block;

endmodule

`default_nettype wire

// ===== rtl/bett_ctrl.sv =====
`default_nettype none

module bett_ctrl #(
  parameter int unsigned MAX_EVENTS = bett_pkg::MAX_EVENTS_DEF,
  parameter int unsigned AW         = 6,
  parameter int unsigned CW         = 7
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [bett_pkg::SPB_W-1:0]  spb_i,
  bett_in_if.sink                          in_i,
  output logic                             mem_we_o,
  output logic [AW-1:0]                    mem_waddr_o,
  output bett_pkg::event_t                 mem_wdata_o,
  output logic                             mem_re_o,
  output logic [AW-1:0]                    mem_raddr_o,
  input  wire bett_pkg::event_t            mem_rdata_i,
  output bett_pkg::push_t                  push_o,
  input  wire logic                        out_free_i
);

  localparam int unsigned EW = bett_pkg::START_W + 1;

  bett_pkg::state_e state_q, state_d;

  logic [CW-1:0]               count_q;
  logic [MAX_EVENTS-1:0]       fired_q;
  logic [bett_pkg::START_W-1:0] last_start_q;
  logic                        last_valid_q;
  logic [bett_pkg::START_W-1:0] start_q;
  logic [EW-1:0]               end_q;

  // scan pipeline: issue index, read stage, product stage
  logic [CW-1:0]               idx0_q;
  logic                        v1_q;
  logic [AW-1:0]               idx1_q;
  logic                        v2_q;
  logic [AW-1:0]               idx2_q;
  logic [bett_pkg::BEAT_W-1:0] pos2_q;
  logic [bett_pkg::SAMP_W-1:0] samp2_q;
  logic [bett_pkg::VEL_W-1:0]  vel2_q;

  // pending hit, held until it is known whether it ends the block
  logic                        pend_v_q;
  bett_pkg::res_t              pend_q;

  logic                        acc;
  logic                        issue;
  logic                        hit;
  logic                        stall;
  logic                        adv;
  logic                        drain;
  logic                        can_add;
  logic [63:0]                 prod;
  logic [EW-1:0]               pos_ext;

  assign in_i.ready = (state_q == bett_pkg::ST_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign can_add    = (count_q < CW'(MAX_EVENTS));

  // append write into the event memory
  assign mem_we_o    = acc && (in_i.mode == bett_pkg::MODE_ADD) && can_add;
  assign mem_waddr_o = count_q[AW-1:0];
  assign mem_wdata_o = '{beat:     in_i.beat_position,
                         sample:   in_i.sample_id_in,
                         velocity: in_i.velocity_in};

  // scan handshake between stages
  assign pos_ext  = EW'(pos2_q);
  assign issue    = (state_q == bett_pkg::ST_SCAN) && (idx0_q < count_q);
  assign hit      = v2_q && !fired_q[idx2_q] &&
                    (pos_ext >= EW'(start_q)) && (pos_ext < end_q);
  assign stall    = hit && pend_v_q && !out_free_i;
  assign adv      = (state_q == bett_pkg::ST_SCAN) && !stall;
  assign drain    = (state_q == bett_pkg::ST_SCAN) && !issue && !v1_q && !v2_q;

  assign mem_re_o    = issue && adv;
  assign mem_raddr_o = idx0_q[AW-1:0];

  // sample position multiply, registered before the window compare
  assign prod = 64'(mem_rdata_i.beat) * 64'(spb_i);

  // result push: older hit goes out when a newer one arrives or at the end
  always_comb begin
    push_o.push = 1'b0;
    push_o.res  = pend_q;
    if (adv && hit && pend_v_q) begin
      push_o.push              = 1'b1;
      push_o.res.last_in_block = 1'b0;
    end else if (drain && pend_v_q && out_free_i) begin
      push_o.push              = 1'b1;
      push_o.res.last_in_block = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bett_pkg::ST_IDLE: begin
        if (acc && (in_i.mode == bett_pkg::MODE_BLOCK) && in_i.playing &&
            (count_q != '0)) begin
          state_d = bett_pkg::ST_SCAN;
        end
      end
      bett_pkg::ST_SCAN: begin
        if (drain && (!pend_v_q || out_free_i)) begin
          state_d = bett_pkg::ST_IDLE;
        end
      end
      default: state_d = bett_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bett_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // table control state and fired flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      fired_q      <= '0;
      last_start_q <= '0;
      last_valid_q <= 1'b0;
      idx0_q       <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      pend_v_q     <= 1'b0;
    end else begin
      if (acc) begin
        unique case (in_i.mode)
          bett_pkg::MODE_ADD: begin
            if (can_add) begin
              fired_q[count_q[AW-1:0]] <= 1'b0;
              count_q                  <= count_q + 1'b1;
            end
          end
          bett_pkg::MODE_CLEAR: begin
            count_q <= '0;
            fired_q <= '0;
          end
          bett_pkg::MODE_BLOCK: begin
            if (last_valid_q && (in_i.block_start < last_start_q)) begin
              fired_q <= '0;
            end
            last_start_q <= in_i.block_start;
            last_valid_q <= 1'b1;
            idx0_q       <= '0;
            v1_q         <= 1'b0;
            v2_q         <= 1'b0;
          end
          default: ;
        endcase
      end
      if (adv) begin
        idx0_q <= idx0_q + CW'(issue);
        v1_q   <= issue;
        v2_q   <= v1_q;
        if (hit) begin
          fired_q[idx2_q] <= 1'b1;
          pend_v_q        <= 1'b1;
        end
      end
      if (drain && pend_v_q && out_free_i) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  // scan payload registers
  always_ff @(posedge clk_i) begin
    if (acc && (in_i.mode == bett_pkg::MODE_BLOCK)) begin
      start_q <= in_i.block_start;
      end_q   <= EW'(in_i.block_start) + EW'(in_i.block_length);
    end
    if (adv) begin
      idx1_q <= idx0_q[AW-1:0];
      if (v1_q) begin
        pos2_q  <= prod[63:32];
        samp2_q <= mem_rdata_i.sample;
        vel2_q  <= mem_rdata_i.velocity;
        idx2_q  <= idx1_q;
      end
      if (hit) begin
        pend_q.fired_sample   <= samp2_q;
        pend_q.fired_velocity <= vel2_q;
        pend_q.fired_slot     <= bett_pkg::SLOT_W'(idx2_q);
        pend_q.last_in_block  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/beat_event_trigger_table.sv =====
`default_nettype none

// Beat event trigger table. Mode 0 beats append an event (ignored when the
// table holds MAX_EVENTS), mode 1 empties the table, mode 2 handles one audio
// block: a start below the previous one re-arms all events, then, while
// playing, every unfired event whose sample position (beat_position times
// samples_per_beat, Q16.16, truncated) lies in [start, start+length) is sent
// out in table order with last_in_block set on the final one. Add, clear and
// stopped blocks do not leave the idle state. In a playing block the scan reads
// one entry per cycle from the event memory read port, followed by the multiply
// and window-compare stages; it pauses while the output is stalled. Input is
// not accepted during a scan. The user must write samples_per_beat through
// cfg_we_i/cfg_wdata_i only while the block is idle; it does not enforce this.
module beat_event_trigger_table #(
  parameter int unsigned MAX_EVENTS = bett_pkg::MAX_EVENTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bett_pkg::SPB_W-1:0]  cfg_wdata_i,
  bett_in_if.sink                          in_i,
  bett_out_if.source                       out_o
);

  localparam int unsigned AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EVENTS + 1);

  logic [bett_pkg::SPB_W-1:0] spb_q;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  bett_pkg::event_t           mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  bett_pkg::event_t           mem_rdata;
  bett_pkg::push_t            push;
  logic                       out_free;

  // samples per beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q <= bett_pkg::SPB_RESET;
    end else if (cfg_we_i) begin
      spb_q <= cfg_wdata_i;
    end
  end

  bett_event_mem #(
    .DEPTH (MAX_EVENTS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bett_ctrl #(
    .MAX_EVENTS (MAX_EVENTS),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .spb_i       (spb_q),
    .in_i        (in_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .push_o      (push),
    .out_free_i  (out_free)
  );

  bett_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
